>>> design/dpq_pkg.sv
`timescale 1ns / 1ps

package dpq_pkg;

  // Sizing
  localparam int PALETTE_ENTRIES = 256;
  localparam int DITHER_SIZE     = 8;
  localparam int ADDR_W          = $clog2(PALETTE_ENTRIES);
  localparam int CNT_W           = $clog2(PALETTE_ENTRIES + 1);

  // Field widths
  localparam int PIX_W      = 10;
  localparam int COORD_W    = 3;
  localparam int COMP_W     = 8;
  localparam int ENTRY_W    = 8;
  localparam int COLOR_W    = 8;
  localparam int RGB_W      = 3 * COMP_W;
  localparam int THR_W      = 7;
  localparam int CH_SUM_W   = PIX_W + 1;
  localparam int SQ_W       = 2 * COMP_W;
  localparam int DIST_W     = 18;
  localparam int COEF_W     = 16;
  localparam int LUMA_ACC_W = COEF_W + COMP_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 1;

  localparam logic [DIST_W-1:0]   DIST_START = DIST_W'(196609);
  localparam logic [CH_SUM_W-1:0] PIX_MAX    = CH_SUM_W'(1020);

  // Luminance weights, Q0.16
  localparam logic [COEF_W-1:0] LUMA_R = COEF_W'(19589);
  localparam logic [COEF_W-1:0] LUMA_G = COEF_W'(38470);
  localparam logic [COEF_W-1:0] LUMA_B = COEF_W'(7471);

  // Scan windows
  localparam int SUB_START = 16;
  localparam int SUB_END   = 32;
  localparam int NORM_END  = 248;
  localparam int FULL_END  = 255;

  function automatic int cap_end(int e);
    return (e > PALETTE_ENTRIES) ? PALETTE_ENTRIES : e;
  endfunction

  localparam logic [CNT_W-1:0] START_SUB = CNT_W'(SUB_START);
  localparam logic [CNT_W-1:0] LAST_SUB  = CNT_W'(cap_end(SUB_END) - 1);
  localparam logic [CNT_W-1:0] LAST_NORM = CNT_W'(cap_end(NORM_END) - 1);
  localparam logic [CNT_W-1:0] LAST_FULL = CNT_W'(cap_end(FULL_END) - 1);

  typedef enum logic [0:0] {
    OP_QUANTIZE = 1'b0,
    OP_WRITE    = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DITHER    = 2'd0,
    CFG_GRAY_SUB  = 2'd1,
    CFG_GRAY_FULL = 2'd2
  } cfg_reg_t;

  // Bayer 8x8 thresholds in quarter units, [row][column]
  typedef logic [THR_W-1:0] bayer_tbl_t [8][8];
  localparam bayer_tbl_t BAYER = '{
    '{7'd1,  7'd49, 7'd13, 7'd61, 7'd4,  7'd52, 7'd16, 7'd64},
    '{7'd33, 7'd17, 7'd45, 7'd29, 7'd36, 7'd20, 7'd48, 7'd32},
    '{7'd9,  7'd57, 7'd5,  7'd53, 7'd12, 7'd60, 7'd8,  7'd56},
    '{7'd41, 7'd25, 7'd37, 7'd21, 7'd44, 7'd28, 7'd40, 7'd24},
    '{7'd3,  7'd51, 7'd15, 7'd63, 7'd2,  7'd50, 7'd14, 7'd62},
    '{7'd35, 7'd19, 7'd47, 7'd31, 7'd34, 7'd18, 7'd46, 7'd30},
    '{7'd11, 7'd59, 7'd7,  7'd55, 7'd10, 7'd58, 7'd6,  7'd54},
    '{7'd43, 7'd27, 7'd39, 7'd23, 7'd42, 7'd26, 7'd38, 7'd22}
  };

  // Coordinate wrap to the threshold map size, built at elaboration
  typedef logic [COORD_W-1:0] wrap_tbl_t [8];

  function automatic wrap_tbl_t build_wrap();
    wrap_tbl_t t;
    for (int i = 0; i < 8; i++) begin
      t[i] = COORD_W'(i % DITHER_SIZE);
    end
    return t;
  endfunction

  localparam wrap_tbl_t COORD_WRAP = build_wrap();

endpackage

>>> design/dpq_if.sv
`timescale 1ns / 1ps

interface dpq_in_if;
  logic                                  valid;
  logic                                  ready;
  dpq_pkg::opcode_t                      opcode;
  logic [dpq_pkg::PIX_W-1:0]             pixel_red;
  logic [dpq_pkg::PIX_W-1:0]             pixel_green;
  logic [dpq_pkg::PIX_W-1:0]             pixel_blue;
  logic [dpq_pkg::COORD_W-1:0]           x_low;
  logic [dpq_pkg::COORD_W-1:0]           y_low;
  logic [dpq_pkg::ENTRY_W-1:0]           entry_index;
  logic [dpq_pkg::COMP_W-1:0]            entry_red;
  logic [dpq_pkg::COMP_W-1:0]            entry_green;
  logic [dpq_pkg::COMP_W-1:0]            entry_blue;

  modport source (
    output valid, opcode, pixel_red, pixel_green, pixel_blue, x_low, y_low,
           entry_index, entry_red, entry_green, entry_blue,
    input  ready
  );
  modport sink (
    input  valid, opcode, pixel_red, pixel_green, pixel_blue, x_low, y_low,
           entry_index, entry_red, entry_green, entry_blue,
    output ready
  );
endinterface

interface dpq_out_if;
  logic                          valid;
  logic                          ready;
  logic [dpq_pkg::COLOR_W-1:0]   color_index;

  modport source (output valid, color_index, input ready);
  modport sink (input valid, color_index, output ready);
endinterface

interface dpq_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [dpq_pkg::CFG_IDX_W-1:0]    index;
  logic [dpq_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> design/dithered_palette_quantizer.sv
`timescale 1ns / 1ps

// Nearest-color quantizer over a 256-entry RGB palette with ordered dither.
// in_ch carries words of two kinds. A write word (opcode OP_WRITE) loads one
// palette entry and returns nothing. A quantize word
// (opcode OP_QUANTIZE) carries an 8.2 RGB pixel and its low x/y bits and
// returns one color_index word on out_ch.
// cfg_ch is always ready; write it only while no quantize word is in work.
// A quantize word scans N palette entries (248 normally, 16 in gray_subrange,
// 255 in gray_full_palette, 239 with both) and puts the result word into the
// output register; in gray_full_palette mode the luminance multiplies run
// before the scan. The next word is taken once the result is in the output
// register. An exact color match ends the scan early. The scan is paced by the
// single palette read port: one entry per cycle.
// in_ch.ready is high only between quantize words; write words go through
// back to back.
// out_ch holds its word in an output register until taken; a stalled
// receiver lets the next scan run, and only the hand-over of that scan's
// result waits.
// Reset clears the configuration registers and all control state. The
// palette is not cleared: scan only entries that were written.
module dithered_palette_quantizer (
  input  logic        clk,
  input  logic        rst_n,
  dpq_in_if.sink      in_ch,
  dpq_out_if.source   out_ch,
  dpq_cfg_if.sink     cfg_ch
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LUMA,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic dither;
    logic gray_sub;
    logic gray_full;
  } cfg_t;

  localparam logic [1:0] LUMA_LAST_STEP = 2'd2;

  state_t state_r;
  cfg_t   cfg_r;

  // Pixel being quantized
  logic [dpq_pkg::COMP_W-1:0]     pix_r_r, pix_g_r, pix_b_r;

  // Luminance multiply-accumulate
  logic [dpq_pkg::LUMA_ACC_W-1:0] acc_r, acc_nxt, prod_w;
  logic [1:0]                     luma_step_r;
  logic [dpq_pkg::COEF_W-1:0]     coef_w;
  logic [dpq_pkg::COMP_W-1:0]     luma_ch_w;

  // Scan address generator
  logic [dpq_pkg::CNT_W-1:0]      rd_addr_r, scan_last_r;
  logic                           iss_on_r;
  logic                           rd_en;

  // Read stage and distance stage
  logic                           s1_vld_r, s1_last_r;
  logic [dpq_pkg::ADDR_W-1:0]     s1_idx_r;
  logic [dpq_pkg::RGB_W-1:0]      rd_data_r;
  logic                           s2_vld_r, s2_last_r;
  logic [dpq_pkg::ADDR_W-1:0]     s2_idx_r;
  logic [dpq_pkg::DIST_W-1:0]     dist_r, dist_nxt;
  logic                           scan_stop;

  // Running minimum
  logic [dpq_pkg::DIST_W-1:0]     best_r;
  logic [dpq_pkg::ADDR_W-1:0]     best_idx_r;

  // Output register
  logic                           out_valid_r;
  logic [dpq_pkg::COLOR_W-1:0]    out_color_r;
  logic                           out_load;

  // Palette store, {red, green, blue}
  logic [dpq_pkg::RGB_W-1:0]      pal_mem [dpq_pkg::PALETTE_ENTRIES];
  logic                           mem_we;

  logic                           in_fire;
  logic [dpq_pkg::THR_W-1:0]      thr_w;
  logic [dpq_pkg::COMP_W-1:0]     ch_r_w, ch_g_w, ch_b_w;

  function automatic logic [dpq_pkg::COMP_W-1:0] chan_q(
    logic [dpq_pkg::PIX_W-1:0] raw,
    logic [dpq_pkg::THR_W-1:0] thr
  );
    logic [dpq_pkg::CH_SUM_W-1:0] c;
    c = {1'b0, raw} + dpq_pkg::CH_SUM_W'(thr);
    if (c > dpq_pkg::PIX_MAX) begin
      c = dpq_pkg::PIX_MAX;
    end
    return c[dpq_pkg::CH_SUM_W-2:2];
  endfunction

  function automatic logic [dpq_pkg::SQ_W-1:0] sq_diff(
    logic [dpq_pkg::COMP_W-1:0] a,
    logic [dpq_pkg::COMP_W-1:0] b
  );
    logic [dpq_pkg::COMP_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return dpq_pkg::SQ_W'(d) * dpq_pkg::SQ_W'(d);
  endfunction

  assign in_ch.ready        = (state_r == S_IDLE);
  assign in_fire            = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.color_index = out_color_r;

  // Threshold lookup and channel clamp for the incoming pixel
  assign thr_w = cfg_r.dither
               ? dpq_pkg::BAYER[dpq_pkg::COORD_WRAP[in_ch.y_low]]
                               [dpq_pkg::COORD_WRAP[in_ch.x_low]]
               : '0;
  assign ch_r_w = chan_q(in_ch.pixel_red,   thr_w);
  assign ch_g_w = chan_q(in_ch.pixel_green, thr_w);
  assign ch_b_w = chan_q(in_ch.pixel_blue,  thr_w);

  // Shared multiplier: one weighted channel per step
  always_comb begin
    unique case (luma_step_r)
      2'd0: begin
        coef_w    = dpq_pkg::LUMA_R;
        luma_ch_w = pix_r_r;
      end
      2'd1: begin
        coef_w    = dpq_pkg::LUMA_G;
        luma_ch_w = pix_g_r;
      end
      2'd2: begin
        coef_w    = dpq_pkg::LUMA_B;
        luma_ch_w = pix_b_r;
      end
      default: begin
        coef_w    = '0;
        luma_ch_w = '0;
      end
    endcase
  end

  assign prod_w  = dpq_pkg::LUMA_ACC_W'(coef_w) * dpq_pkg::LUMA_ACC_W'(luma_ch_w);
  assign acc_nxt = acc_r + prod_w;

  // Squared distance of the entry just read
  assign dist_nxt =
      dpq_pkg::DIST_W'(sq_diff(pix_r_r, rd_data_r[3*dpq_pkg::COMP_W-1:2*dpq_pkg::COMP_W]))
    + dpq_pkg::DIST_W'(sq_diff(pix_g_r, rd_data_r[2*dpq_pkg::COMP_W-1:dpq_pkg::COMP_W]))
    + dpq_pkg::DIST_W'(sq_diff(pix_b_r, rd_data_r[dpq_pkg::COMP_W-1:0]));

  // End the scan on an exact match or after the last entry of the window
  assign scan_stop = s2_vld_r && ((dist_r == '0) || s2_last_r);
  // Load the output register once the scan is done and the register is free
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  assign rd_en  = (state_r == S_SCAN) && iss_on_r;
  assign mem_we = in_fire && (in_ch.opcode == dpq_pkg::OP_WRITE)
               && ({1'b0, in_ch.entry_index}
                   < (dpq_pkg::ENTRY_W + 1)'(dpq_pkg::PALETTE_ENTRIES));

  // Palette memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      pal_mem[in_ch.entry_index[dpq_pkg::ADDR_W-1:0]] <=
        {in_ch.entry_red, in_ch.entry_green, in_ch.entry_blue};
    end
    if (rd_en) begin
      rd_data_r <= pal_mem[rd_addr_r[dpq_pkg::ADDR_W-1:0]];
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        dpq_pkg::CFG_DITHER:    cfg_r.dither    <= cfg_ch.data[0];
        dpq_pkg::CFG_GRAY_SUB:  cfg_r.gray_sub  <= cfg_ch.data[0];
        dpq_pkg::CFG_GRAY_FULL: cfg_r.gray_full <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // Sequencer, scan pipeline and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iss_on_r    <= 1'b0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Raise the output word on load, drop it once taken
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire && (in_ch.opcode == dpq_pkg::OP_QUANTIZE)) begin
            pix_r_r     <= ch_r_w;
            pix_g_r     <= ch_g_w;
            pix_b_r     <= ch_b_w;
            acc_r       <= '0;
            luma_step_r <= '0;
            best_r      <= dpq_pkg::DIST_START;
            best_idx_r  <= '0;
            rd_addr_r   <= cfg_r.gray_sub ? dpq_pkg::START_SUB : '0;
            priority if (cfg_r.gray_full) begin
              scan_last_r <= dpq_pkg::LAST_FULL;
            end else if (cfg_r.gray_sub) begin
              scan_last_r <= dpq_pkg::LAST_SUB;
            end else begin
              scan_last_r <= dpq_pkg::LAST_NORM;
            end
            if (cfg_r.gray_full) begin
              state_r <= S_LUMA;
            end else begin
              state_r  <= S_SCAN;
              iss_on_r <= 1'b1;
            end
          end
        end

        S_LUMA: begin
          acc_r       <= acc_nxt;
          luma_step_r <= luma_step_r + 2'd1;
          if (luma_step_r == LUMA_LAST_STEP) begin
            // Replace all three channels by the gray value
            pix_r_r  <= acc_nxt[dpq_pkg::LUMA_ACC_W-1:dpq_pkg::COEF_W];
            pix_g_r  <= acc_nxt[dpq_pkg::LUMA_ACC_W-1:dpq_pkg::COEF_W];
            pix_b_r  <= acc_nxt[dpq_pkg::LUMA_ACC_W-1:dpq_pkg::COEF_W];
            state_r  <= S_SCAN;
            iss_on_r <= 1'b1;
          end
        end

        S_SCAN: begin
          if (scan_stop) begin
            // Flush the pipeline and hand over the result
            state_r  <= S_DONE;
            iss_on_r <= 1'b0;
            s1_vld_r <= 1'b0;
            s2_vld_r <= 1'b0;
          end else begin
            // Advance the read address
            if (iss_on_r) begin
              rd_addr_r <= rd_addr_r + 1'b1;
              if (rd_addr_r == scan_last_r) begin
                iss_on_r <= 1'b0;
              end
            end
            s1_vld_r <= iss_on_r;
            s2_vld_r <= s1_vld_r;
          end
          s1_idx_r  <= rd_addr_r[dpq_pkg::ADDR_W-1:0];
          s1_last_r <= (rd_addr_r == scan_last_r);
          s2_idx_r  <= s1_idx_r;
          s2_last_r <= s1_last_r;
          dist_r    <= dist_nxt;

          // Strict less-than keeps the first minimum
          if (s2_vld_r && (dist_r < best_r)) begin
            best_r     <= dist_r;
            best_idx_r <= s2_idx_r;
          end
        end

        S_DONE: begin
          // Hold until the output register is free
          if (out_load) begin
            out_color_r <= dpq_pkg::COLOR_W'(best_idx_r);
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!iss_on_r && !s1_vld_r && !s2_vld_r))
    else $error("scan pipeline busy while idle");

  a_addr_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    iss_on_r |-> (rd_addr_r <= scan_last_r))
    else $error("scan address past window end");

  a_best_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN) && ($past(state_r) == S_SCAN)) |-> (best_r <= $past(best_r)))
    else $error("running minimum grew during scan");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result word raised outside of scan completion");
`endif

endmodule
